// ===== design/tdtl_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tdtl_pkg: shared types and codes for the task delay timer table
// Transaction structs, opcodes, modes, task states and event codes.
// -----------------------------------------------------------------------------
package tdtl_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SETST  = 2'd3;

  localparam logic [1:0] MODE_RELATIVE = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_ABSOLUTE = 2'd2;
  localparam logic [1:0] MODE_SPARE    = 2'd3;  // unused mode, acts as relative

  localparam logic [2:0] ST_READY     = 3'd0;
  localparam logic [2:0] ST_SUSP      = 3'd2;
  localparam logic [2:0] ST_PEND_SUSP = 3'd3;
  localparam logic [2:0] ST_DLY       = 3'd4;
  localparam logic [2:0] ST_PEND_TO   = 3'd5;
  localparam logic [2:0] ST_DLY_SUSP  = 3'd6;
  localparam logic [2:0] ST_TO_SUSP   = 3'd7;

  localparam logic [2:0] EV_DONE      = 3'd0;
  localparam logic [2:0] EV_DLY_RDY   = 3'd1;
  localparam logic [2:0] EV_TO_RDY    = 3'd2;
  localparam logic [2:0] EV_DLY_SUSP  = 3'd3;
  localparam logic [2:0] EV_TO_SUSP   = 3'd4;
  localparam logic [2:0] EV_ARMED     = 3'd5;
  localparam logic [2:0] EV_ZERO      = 3'd6;

  localparam logic [31:0] THRESH_RESET = 32'hFFFF_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  task_index;
    logic [31:0] delay_time;
    logic [1:0]  time_mode;
    logic [2:0]  task_state;
  } req_t;

  typedef struct packed {
    logic [3:0]  task_id;
    logic [2:0]  event_res;
    logic [31:0] remaining_ticks;
    logic [31:0] tick_count;
    logic        last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, bump counter on tick
    logic exec_op;   // apply insert, remove or set state
    logic scan_step; // examine current scan slot
    logic scan_adv;  // advance scan pointer
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic hit;       // current scan slot expires
    logic scan_end;  // current scan slot is the final one
  } sts_t;

endpackage

// ===== design/tdtl_datapath.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tdtl_datapath: slot table, tick counter and result builder
// Holds per-slot state; executes the commands given by the controller.
// -----------------------------------------------------------------------------
module tdtl_datapath import tdtl_pkg::*; #(
  parameter int NUM_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  req_t        req_i,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  output rsp_t        rsp_o
);
  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  logic [31:0] thresh_q;
  logic [31:0] cnt_q;
  logic [2:0]  st_q  [NUM_TASKS];
  logic [31:0] mt_q  [NUM_TASKS];
  logic [31:0] pm_q  [NUM_TASKS];
  logic [NUM_TASKS-1:0] arm_q;
  req_t        req_q;
  logic [IW-1:0] ptr_q;
  logic        in_range;
  logic [IW-1:0] sidx;

  // addressed slot
  assign sidx     = IW'(req_q.task_index);
  assign in_range = ({28'd0, req_q.task_index} < 32'(NUM_TASKS));

  // insert arithmetic
  logic [31:0] delta, nxt, pmatch, ins_m, ins_r;
  logic        ins_ok;
  logic        ins_hit;
  always_comb begin
    delta  = req_q.delay_time - cnt_q - 32'd1;
    nxt    = pm_q[sidx] + req_q.delay_time;
    pmatch = ((nxt - cnt_q - 32'd1) < req_q.delay_time) ? nxt
             : cnt_q + req_q.delay_time;
    if (req_q.time_mode == MODE_ABSOLUTE) begin
      ins_ok = (delta <= thresh_q);
      ins_m  = req_q.delay_time;
      ins_r  = delta + 32'd1;
    end else if (req_q.time_mode == MODE_PERIODIC) begin
      ins_ok = (req_q.delay_time != 32'd0);
      ins_m  = pmatch;
      ins_r  = pmatch - cnt_q;
    end else begin
      ins_ok = (req_q.delay_time != 32'd0);
      ins_m  = cnt_q + req_q.delay_time;
      ins_r  = req_q.delay_time;
    end
  end

  assign ins_hit = in_range && (req_q.opcode == OP_INSERT);

  // scan decode
  logic [2:0] sev, snext;
  logic       sexp;
  always_comb begin
    sexp = 1'b1;
    sev = EV_DONE;
    snext = ST_READY;
    case (st_q[ptr_q])
      ST_DLY:      begin sev = EV_DLY_RDY;  snext = ST_READY; end
      ST_PEND_TO:  begin sev = EV_TO_RDY;   snext = ST_READY; end
      ST_DLY_SUSP: begin sev = EV_DLY_SUSP; snext = ST_SUSP;  end
      ST_TO_SUSP:  begin sev = EV_TO_SUSP;  snext = ST_SUSP;  end
      default:     sexp = 1'b0;
    endcase
  end

  assign sts_o.is_tick  = (req_q.opcode == OP_TICK);
  assign sts_o.hit      = sexp && arm_q[ptr_q] && (mt_q[ptr_q] == cnt_q);
  assign sts_o.scan_end = (ptr_q == IW'(NUM_TASKS - 1));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      cnt_q    <= '0;
      arm_q    <= '0;
      ptr_q    <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        st_q[i] <= ST_READY;
        mt_q[i] <= '0;
        pm_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) thresh_q <= cfg_data_i;
      if (ctl_i.load) begin
        ptr_q <= '0;
        if (req_i.opcode == OP_TICK) cnt_q <= cnt_q + 32'd1;
      end
      if (ctl_i.scan_adv) ptr_q <= ptr_q + IW'(1);
      if (ctl_i.scan_step && sts_o.hit) begin
        st_q[ptr_q]  <= snext;
        arm_q[ptr_q] <= 1'b0;
        mt_q[ptr_q]  <= '0;
      end
      if (ctl_i.exec_op && in_range) begin
        case (req_q.opcode)
          OP_INSERT: begin
            arm_q[sidx] <= ins_ok;
            mt_q[sidx]  <= ins_ok ? ins_m : 32'd0;
            if (ins_ok && req_q.time_mode == MODE_PERIODIC) pm_q[sidx] <= ins_m;
          end
          OP_REMOVE: begin
            arm_q[sidx] <= 1'b0;
            mt_q[sidx]  <= '0;
          end
          OP_SETST: st_q[sidx] <= req_q.task_state;
          default: ;
        endcase
      end
    end
  end

  // request capture and result build
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) req_q <= req_i;
    if (ctl_i.exec_op) begin
      rsp_o.task_id         <= req_q.task_index;
      rsp_o.tick_count      <= cnt_q;
      rsp_o.last            <= 1'b1;
      rsp_o.event_res       <= ins_hit ? (ins_ok ? EV_ARMED : EV_ZERO) : EV_DONE;
      rsp_o.remaining_ticks <= (ins_hit && ins_ok) ? ins_r : 32'd0;
    end else if (ctl_i.scan_step) begin
      rsp_o.task_id         <= 4'(ptr_q);
      rsp_o.event_res       <= sev;
      rsp_o.remaining_ticks <= '0;
      rsp_o.tick_count      <= cnt_q;
      rsp_o.last            <= 1'b0;
    end else if (ctl_i.scan_adv) begin
      // terminator
      rsp_o.task_id         <= '0;
      rsp_o.event_res       <= EV_DONE;
      rsp_o.remaining_ticks <= '0;
      rsp_o.tick_count      <= cnt_q;
      rsp_o.last            <= 1'b1;
    end
  end
endmodule

// ===== design/tdtl_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tdtl_ctrl: sequencer for the task delay timer table
// Accepts a transaction, drives the op or the slot scan, presents results.
// -----------------------------------------------------------------------------
module tdtl_ctrl import tdtl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);
  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_TERM, S_OUT, S_SOUT} state_e;
  state_e state_q, state_d;
  logic   outv_q, outv_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == S_IDLE) && !outv_q;
  assign out_valid_o = outv_q;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    outv_d  = outv_q && !out_ready_i;
    ctl_o   = '0;
    ctl_o.load = in_acc;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_DECODE;
      S_DECODE: begin
        if (sts_i.is_tick) state_d = S_SCAN;
        else begin
          ctl_o.exec_op = 1'b1;
          outv_d  = 1'b1;
          state_d = S_OUT;
        end
      end
      S_SCAN: begin
        if (!outv_d) begin
          if (sts_i.hit) begin
            ctl_o.scan_step = 1'b1;
            outv_d = 1'b1;
          end
          ctl_o.scan_adv = !sts_i.scan_end;
          if (sts_i.scan_end) state_d = S_TERM;
        end
      end
      S_TERM: begin
        if (!outv_d) begin
          ctl_o.scan_adv = 1'b1;
          outv_d  = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: if (!outv_d) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      outv_q  <= outv_d;
    end
  end
endmodule

// ===== design/task_delay_timer_list.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// task_delay_timer_list: task delay timer table, one slot per task
// Insert, remove and set-state transactions give one result; ticks scan slots.
// -----------------------------------------------------------------------------
// An insert, remove or set-state is executed in the decode state and returns
// one result. A tick walks the slots one per cycle through the controller's
// scan loop while no expiry result is waiting, reporting each expired slot and
// ending with a terminator marked last. A new transaction
// is taken once the last result has been accepted.
module task_delay_timer_list import tdtl_pkg::*; #(
  parameter int NUM_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o
);
  ctl_t ctl;
  sts_t sts;

  tdtl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  tdtl_datapath #(.NUM_TASKS(NUM_TASKS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .req_i(in_data_i),
    .ctl_i(ctl), .sts_o(sts), .rsp_o(out_data_o)
  );
endmodule

// ===== design/tdtl_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tdtl_checker: port-level assertions for the task delay timer table
// Checks handshake holding and result framing over time.
// -----------------------------------------------------------------------------
module tdtl_checker import tdtl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);
  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // no new transaction while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // a result marked last carries done, armed or zero, never an expiry event
  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last && out_data_o.event_res != EV_ARMED &&
    out_data_o.event_res != EV_ZERO && out_data_o.event_res != EV_DONE |-> 1'b0)
    else $error("last result with expiry event");

  // accepted input never yields a result in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result too early");
endmodule

bind task_delay_timer_list tdtl_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .out_data_o
);

// ===== bench/tb_task_delay_timer_list.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_task_delay_timer_list: self-checking bench for the task delay timer table
// Drives tick, insert, remove and set-state transactions with random gaps and
// output stalls, predicts every result from a local copy of the slot table and
// compares each result field by field in arrival order.
// -----------------------------------------------------------------------------
module tb_task_delay_timer_list;
  import tdtl_pkg::*;

  localparam int NT = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_data_o;

  // timer table mirror
  logic [31:0] thresh_m;
  logic [31:0] ticks_m;
  logic [2:0]  state_m [NT];
  logic [31:0] match_m [NT];
  logic [31:0] prev_m  [NT];
  logic        armed_m [NT];

  rsp_t        pending_rsp[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          hold_off = 0;
  bit          stall_free = 1'b0;

  task_delay_timer_list #(.NUM_TASKS(NT)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic rsp_t mk_rsp(logic [3:0] id, logic [2:0] ev, logic [31:0] rem,
                                  logic fin);
    rsp_t r;
    r.task_id = id;
    r.event_res = ev;
    r.remaining_ticks = rem;
    r.tick_count = ticks_m;
    r.last = fin;
    return r;
  endfunction

  // compute the results of one transaction and advance the mirror
  task automatic predict_timer(req_t q);
    logic [31:0] m, r, delta, nxt;
    logic [2:0]  ev, nst;
    int          i;
    ev = EV_DONE;
    r = '0;
    if (q.opcode == OP_TICK) begin
      ticks_m = ticks_m + 1;
      for (i = 0; i < NT; i++) begin
        if (armed_m[i] && match_m[i] == ticks_m && state_m[i] >= ST_DLY) begin
          case (state_m[i])
            ST_DLY:     begin ev = EV_DLY_RDY;  nst = ST_READY; end
            ST_PEND_TO: begin ev = EV_TO_RDY;   nst = ST_READY; end
            ST_DLY_SUSP: begin ev = EV_DLY_SUSP; nst = ST_SUSP; end
            default:    begin ev = EV_TO_SUSP;  nst = ST_SUSP;  end
          endcase
          state_m[i] = nst;
          armed_m[i] = 1'b0;
          match_m[i] = '0;
          pending_rsp.push_back(mk_rsp(i[3:0], ev, '0, 1'b0));
        end
      end
      pending_rsp.push_back(mk_rsp('0, EV_DONE, '0, 1'b1));
      return;
    end
    i = q.task_index;
    if (q.opcode == OP_INSERT) begin
      ev = EV_ARMED;
      if (q.time_mode == MODE_ABSOLUTE) begin
        delta = q.delay_time - ticks_m - 1;
        m = q.delay_time;
        r = delta + 1;
        if (delta > thresh_m) ev = EV_ZERO;
      end else if (q.delay_time == 0) begin
        ev = EV_ZERO;
      end else if (q.time_mode == MODE_PERIODIC) begin
        nxt = prev_m[i] + q.delay_time;
        m = (nxt - ticks_m - 1 < q.delay_time) ? nxt : ticks_m + q.delay_time;
        r = m - ticks_m;
        prev_m[i] = m;
      end else begin
        m = ticks_m + q.delay_time;
        r = q.delay_time;
      end
      if (ev == EV_ZERO) begin
        match_m[i] = '0;
        armed_m[i] = 1'b0;
        r = '0;
      end else begin
        match_m[i] = m;
        armed_m[i] = 1'b1;
      end
    end else if (q.opcode == OP_REMOVE) begin
      armed_m[i] = 1'b0;
      match_m[i] = '0;
    end else begin
      state_m[i] = q.task_state;
    end
    pending_rsp.push_back(mk_rsp(q.task_index, ev, r, 1'b1));
  endtask

  // offer one transaction after a random gap, predict on acceptance
  task automatic send_item(req_t q);
    int g;
    g = gap_len();
    repeat (g) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timer(q);
    // drop valid and let the edge pass before the next offer
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_op(logic [1:0] op, int idx, logic [31:0] t, logic [1:0] md,
                         logic [2:0] st);
    req_t q;
    q.opcode = op;
    q.task_index = idx[3:0];
    q.delay_time = t;
    q.time_mode = md;
    q.task_state = st;
    send_item(q);
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (NT + 8) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [31:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thresh_m = v;
  endtask

  // receiver stalls: random gaps, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (stall_free) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) < 65);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data_o.task_id !== want.task_id ||
            out_data_o.event_res !== want.event_res ||
            out_data_o.remaining_ticks !== want.remaining_ticks ||
            out_data_o.tick_count !== want.tick_count ||
            out_data_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", want, out_data_o);
        end
      end
    end
  end

  task automatic test_directed();
    int i;
    // arm and expire every state kind that can expire
    send_op(OP_SETST, 0, '0, '0, ST_DLY);
    send_op(OP_SETST, 1, '0, '0, ST_PEND_TO);
    send_op(OP_SETST, 2, '0, '0, ST_DLY_SUSP);
    send_op(OP_SETST, 15, '0, '0, ST_TO_SUSP);
    send_op(OP_SETST, 3, '0, '0, ST_PEND_SUSP);
    for (i = 0; i < 4; i++)
      send_op(OP_INSERT, (i == 3) ? 15 : i, 32'd2, MODE_RELATIVE, '0);
    send_op(OP_INSERT, 3, 32'd2, MODE_SPARE, '0);
    send_op(OP_INSERT, 4, 32'd0, MODE_RELATIVE, '0);
    send_op(OP_INSERT, 5, 32'd0, MODE_PERIODIC, '0);
    send_op(OP_INSERT, 6, 32'hFFFF_FFFF, MODE_PERIODIC, '0);
    send_op(OP_INSERT, 7, 32'd0, MODE_ABSOLUTE, '0);
    send_op(OP_INSERT, 8, 32'd5, MODE_ABSOLUTE, '0);
    send_op(OP_INSERT, 9, 32'hFFFF_FFFF, MODE_RELATIVE, ST_TO_SUSP);
    send_op(OP_TICK, 0, '0, '0, '0);
    send_op(OP_TICK, 0, '0, '0, '0);
    send_op(OP_REMOVE, 8, '0, '0, '0);
    send_op(OP_REMOVE, 8, '0, '0, '0);
    send_op(OP_INSERT, 6, 32'd3, MODE_PERIODIC, '0);
    send_op(OP_INSERT, 6, 32'd3, MODE_PERIODIC, '0);
    send_op(OP_TICK, 0, '0, '0, '0);
  endtask

  function automatic req_t rand_req();
    req_t q;
    int k;
    q = '0;
    k = $urandom_range(0, 99);
    q.opcode = (k < 30) ? OP_TICK : (k < 65) ? OP_INSERT : (k < 80) ? OP_REMOVE : OP_SETST;
    q.task_index = 4'($urandom_range(0, NT - 1));
    q.time_mode = 2'($urandom_range(0, 3));
    q.task_state = 3'((k % 2) ? $urandom_range(ST_DLY, ST_TO_SUSP) : $urandom_range(0, 7));
    k = $urandom_range(0, 9);
    if (k < 6) q.delay_time = $urandom_range(1, 6);
    else if (k < 7) q.delay_time = '0;
    else q.delay_time = $urandom();
    if (q.time_mode == MODE_ABSOLUTE && k < 6) q.delay_time = ticks_m + q.delay_time - 2;
    return q;
  endfunction

  task automatic test_random(int n);
    int i;
    for (i = 0; i < n; i++) send_item(rand_req());
  endtask

  task automatic test_backpressure();
    int i;
    hold_off = 300;
    for (i = 0; i < 10; i++) send_item(rand_req());
    wait_drained();
    test_random(10);
  endtask

  task automatic test_thresholds();
    write_thresh(32'd0);
    test_random(40);
    write_thresh(32'hFFFF_FFFF);
    test_random(40);
    write_thresh(32'd3);
    test_random(40);
    write_thresh(THRESH_RESET);
  endtask

  initial begin
    int i;
    thresh_m = THRESH_RESET;
    ticks_m = '0;
    for (i = 0; i < NT; i++) begin
      state_m[i] = ST_READY;
      match_m[i] = '0;
      prev_m[i] = '0;
      armed_m[i] = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_thresholds();
    stall_free = 1'b1;
    test_random(40);
    stall_free = 1'b0;
    test_random(120);
    wait_drained();
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
